[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/b2d_pkg.sv]
// ----------------------------------------------------------------------------
// b2d_pkg
// Constants shared by the binary to decimal ASCII digit converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 6;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

endpackage

[rtl/core/binary_to_decimal_ascii_digits_top.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits_top
// Converts a 32-bit unsigned value into ASCII decimal digits, one beat each.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (value, value_valid, value_ready) takes one 32-bit
//   unsigned value per beat. The output channel (digit_char, last_digit,
//   digit_valid, digit_ready) returns its decimal digits as ASCII codes,
//   most significant first, leading zeros suppressed, one digit per beat.
//   last_digit marks the final digit of a value. Zero yields a single '0'.
//   Only the MAX_DIGITS least significant decimal digits are kept.
// Pipeline and rate:
//   The double-dabble conversion runs in an 8-stage pipeline, four
//   shift-add-3 steps per stage, followed by the digit serializer. The
//   serializer gives one digit per cycle while digit_ready is high; a
//   value has 1 to 10 digits. The pipeline accepts a new value every
//   cycle while it has room.
// Reset and stalls:
//   Synchronous reset clears all valid bits and the serializer busy flag; data
//   registers are not cleared. When digit_ready is low, the serializer
//   holds its digit, the pipeline fills up stage by stage and value_ready
//   drops once every stage holds a value. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_to_decimal_ascii_digits_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [b2d_pkg::VALUE_W-1:0]  value,
  input  logic                         value_valid,
  output logic                         value_ready,
  output logic [b2d_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last_digit,
  output logic                         digit_valid,
  input  logic                         digit_ready
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NS    = b2d_pkg::NUM_STAGES;
  localparam int VW    = b2d_pkg::VALUE_W;

  // Pipeline registers: the BCD accumulator, the binary bits not yet
  // shifted in, and a valid bit per stage.
  logic [BCD_W-1:0] bcd_q [NS];
  logic [VW-1:0]    bin_q [NS];
  logic [NS-1:0]    valid_q;
  logic [NS:0]      en;

  // Serializer registers.
  logic [BCD_W-1:0] hold;
  logic [POS_W-1:0] pos;
  logic             busy;
  logic             ser_take;
  logic [POS_W-1:0] msd;
  logic [3:0]       cur_digit;

  // A stage moves when it is empty or its successor moves too.
  always_comb begin
    en[NS] = ser_take;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign value_ready = en[0];

  genvar gs;
  generate
    for (gs = 0; gs < NS; gs++) begin : g_stage
      logic [BCD_W-1:0] in_bcd;
      logic [VW-1:0]    in_bin;
      logic             in_valid;
      logic [BCD_W-1:0] bcd_next;
      logic [VW-1:0]    bin_next;

      if (gs == 0) begin : g_first
        assign in_bcd   = '0;
        assign in_bin   = value;
        assign in_valid = value_valid;
      end else begin : g_rest
        assign in_bcd   = bcd_q[gs-1];
        assign in_bin   = bin_q[gs-1];
        assign in_valid = valid_q[gs-1];
      end

      // Four shift-add-3 steps: digits of five or more get three added,
      // then the next binary bit shifts in at the bottom.
      always_comb begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int t = 0; t < b2d_pkg::STEPS_PER_STAGE; t++) begin
          for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_next[4*d +: 4] >= 4'd5) begin
              bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
            end
          end
          bcd_next = {bcd_next[BCD_W-2:0], bin_next[VW-1]};
          bin_next = {bin_next[VW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[gs] <= 1'b0;
        end else if (en[gs]) begin
          valid_q[gs] <= in_valid;
        end
        if (en[gs]) begin
          bcd_q[gs] <= bcd_next;
          bin_q[gs] <= bin_next;
        end
      end
    end
  endgenerate

  // Most significant nonzero digit; zero when all digits are zero.
  always_comb begin
    msd = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd_q[NS-1][4*d +: 4] != 4'd0) begin
        msd = POS_W'(d);
      end
    end
  end

  // The serializer takes a new word when idle or on its final beat.
  assign ser_take = !busy || (digit_ready && (pos == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ser_take) begin
      busy <= valid_q[NS-1];
    end
    if (ser_take) begin
      hold <= bcd_q[NS-1];
      pos  <= msd;
    end else if (digit_ready) begin
      pos <= pos - 1'b1;
    end
  end

  assign cur_digit   = hold[4*pos +: 4];
  assign digit_valid = busy;
  assign last_digit  = (pos == '0);
  assign digit_char  = b2d_pkg::ASCII_ZERO +
                       ((cur_digit > 4'd9) ? 6'd0 : {2'b00, cur_digit});

  // A digit beat that is not the last keeps the serializer busy.
  `ASSERT_NEXT(a_busy_holds, busy && digit_ready && (pos != '0), busy, "serializer dropped a value")
  // The digit position never leaves the digit register.
  `ASSERT_CLK(a_pos_range, !busy || (32'(pos) < MAX_DIGITS), "digit position out of range")
  // While stalled, the digit position stays put.
  `ASSERT_NEXT(a_pos_stall, busy && !digit_ready, $stable(pos) && busy, "digit moved during stall")

endmodule

[sim/binary_to_decimal_ascii_digits_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits_top_tb
// Self-checking bench for the binary to decimal ASCII digit converter.
// A directed table of values (zero, single digits, powers of ten, the full
// 32-bit range) is followed by random values of varied magnitude. Every
// value is expanded into its expected digit beats, which are compared in
// order against the output channel while both sides stall at random.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits_top_tb;

  localparam int NDIGITS = 10;

  typedef struct packed {
    logic [b2d_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_beat_t;

  // One row of the directed table. has_text marks rows whose expected text is
  // typed in; the rest are only checked against the predictor.
  typedef struct {
    logic [b2d_pkg::VALUE_W-1:0] val;
    bit                          has_text;
    string                       text;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic [b2d_pkg::VALUE_W-1:0]  value = '0;
  logic                         value_valid = 1'b0;
  logic                         value_ready;
  logic [b2d_pkg::CHAR_W-1:0]   digit_char;
  logic                         last_digit;
  logic                         digit_valid;
  logic                         digit_ready = 1'b0;

  digit_beat_t pending_digits[$];
  int          errors = 0;
  int          values_sent = 0;
  int          digits_seen = 0;

  always #4 clk = ~clk;

  binary_to_decimal_ascii_digits_top #(.MAX_DIGITS(NDIGITS)) uut (
    .clk(clk), .rst(rst), .value(value), .value_valid(value_valid),
    .value_ready(value_ready), .digit_char(digit_char), .last_digit(last_digit),
    .digit_valid(digit_valid), .digit_ready(digit_ready)
  );

  // Predictor: split into decimal digits, keep the low NDIGITS of them, drop
  // leading zeros but always keep at least one digit.
  function automatic void predict_digits(logic [b2d_pkg::VALUE_W-1:0] v);
    logic [3:0]  dec[NDIGITS];
    logic [31:0] rem;
    int          sig;
    digit_beat_t b;
    rem = v;
    sig = 1;
    for (int n = 0; n < NDIGITS; n++) begin
      dec[n] = 4'(rem % 32'd10);
      rem = rem / 32'd10;
      if (dec[n] != 4'd0) sig = n + 1;
    end
    for (int p = sig - 1; p >= 0; p--) begin
      b.ch = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(dec[p]);
      b.last = (p == 0);
      pending_digits.push_back(b);
    end
  endfunction

  // Cross-checks the predicted beats from index base on against typed text.
  function automatic void check_text(logic [b2d_pkg::VALUE_W-1:0] v, string s,
                                     int base);
    int n;
    n = pending_digits.size() - base;
    if (n != s.len()) begin
      $display("%0t: digit count for %0d: expected %0d actual %0d", $time, v,
               s.len(), n);
      errors++;
      return;
    end
    for (int i = 0; i < s.len(); i++)
      if (pending_digits[base + i].ch != b2d_pkg::CHAR_W'(s[i])) begin
        $display("%0t: digit %0d of %0d: expected %0d actual %0d", $time, i, v,
                 b2d_pkg::CHAR_W'(s[i]), pending_digits[base + i].ch);
        errors++;
      end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random value with a spread of magnitudes so short and long runs both occur.
  function automatic logic [b2d_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 9);
    if (r < 4) return $urandom() >> $urandom_range(1, 31);
    return $urandom();
  endfunction

  // Inputs only change at rising edges, so the level seen at the falling edge
  // is the level the next rising edge samples.
  task automatic send_value(logic [b2d_pkg::VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value <= v;
    value_valid <= 1'b1;
    predict_digits(v);
    @(negedge clk);
    while (!value_ready) @(negedge clk);
    @(posedge clk);
    values_sent++;
  endtask

  // Output check: a beat seen with valid and ready at the falling edge is
  // accepted at the following rising edge.
  always @(negedge clk) begin
    digit_beat_t exp_beat;
    if (!rst && digit_valid && digit_ready) begin
      digits_seen++;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit beat: expected none actual %0d last %0b",
                 $time, digit_char, last_digit);
        errors++;
      end else begin
        exp_beat = pending_digits.pop_front();
        if (digit_char !== exp_beat.ch) begin
          $display("%0t: digit_char expected %0d actual %0d", $time,
                   exp_beat.ch, digit_char);
          errors++;
        end
        if (last_digit !== exp_beat.last) begin
          $display("%0t: last_digit expected %0b actual %0b", $time,
                   exp_beat.last, last_digit);
          errors++;
        end
      end
    end
  end

  // Output side: random stalls, with calm stretches.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (stall > 0) begin
        digit_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digit_ready <= 1'b1;
    end
  end

  initial begin
    dir_row_t rows[$];
    int       base;
    rows.push_back('{32'd0, 1'b1, "0"});
    rows.push_back('{32'd1, 1'b1, "1"});
    rows.push_back('{32'd9, 1'b1, "9"});
    rows.push_back('{32'd10, 1'b1, "10"});
    rows.push_back('{32'd99, 1'b1, "99"});
    rows.push_back('{32'd100, 1'b1, "100"});
    rows.push_back('{32'd1000000000, 1'b1, "1000000000"});
    rows.push_back('{32'd999999999, 1'b1, "999999999"});
    rows.push_back('{32'hFFFFFFFF, 1'b1, "4294967295"});
    rows.push_back('{32'h80000000, 1'b1, "2147483648"});
    rows.push_back('{32'h7FFFFFFF, 1'b1, "2147483647"});
    rows.push_back('{32'hAAAAAAAA, 1'b0, ""});
    rows.push_back('{32'h55555555, 1'b0, ""});
    rows.push_back('{32'd1234567890, 1'b1, "1234567890"});
    rows.push_back('{32'd0, 1'b1, "0"});
    rows.push_back('{32'd4000000000, 1'b1, "4000000000"});
    rows.push_back('{32'd100000, 1'b0, ""});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].has_text) begin
        // Predict into the tail of the queue, check it, then take it back out.
        base = pending_digits.size();
        predict_digits(rows[i].val);
        check_text(rows[i].val, rows[i].text, base);
        while (pending_digits.size() > base) void'(pending_digits.pop_back());
      end
      send_value(rows[i].val);
    end
    repeat (233) send_value(pick_value());
    value_valid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Converted %0d values into %0d digit beats under random stalls.",
             values_sent, digits_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
